FILE: design/pnc_pkg.sv
`timescale 1ns / 1ps

package pnc_pkg;

    localparam int CHAN_W = 8;
    localparam int IDX_W = 8;
    localparam int RGB_W = 3 * CHAN_W;
    localparam int ADDR_SPAN = 256;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Largest distance is 3 * 255 * 255 = 195075, which fits in 18 bits.
    localparam int DIST_W = 18;
    localparam int SQ_W = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic             en;
        logic             last;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
    } t_rd_rsp;

    // Gamma level 0: one step brighter, saturating at full scale.
    function automatic logic [CHAN_W-1:0] gamma0(input logic [CHAN_W-1:0] x);
        gamma0 = (x == CHAN_MAX) ? CHAN_MAX : CHAN_W'(x + 1'b1);
    endfunction

endpackage

FILE: design/pnc_palette_mem.sv
`timescale 1ns / 1ps

module pnc_palette_mem #(
    parameter int DEPTH = pnc_pkg::ADDR_SPAN
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [pnc_pkg::IDX_W-1:0]    i_wr_index,
    input  logic [pnc_pkg::RGB_W-1:0]    i_wr_rgb,
    input  pnc_pkg::t_rd_req             i_rd_req,
    output pnc_pkg::t_rd_rsp             o_rd_rsp
);
    import pnc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(DEPTH);

    logic [RGB_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [RGB_W-1:0] r_rd_data;
    logic             r_rd_ok;
    logic             r_rsp_vld;
    logic             r_rsp_last;
    logic [IDX_W-1:0] r_rsp_idx;

    logic          w_wr_ok;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    // Writes beyond the palette are dropped.
    assign w_wr_ok   = i_wr_en && ({1'b0, i_wr_index} < DEPTH_LIM);
    assign w_wr_addr = i_wr_index[AW-1:0];
    assign w_rd_addr = i_rd_req.addr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[w_wr_addr] <= i_wr_rgb;
        end
        if (i_rd_req.en) begin
            r_rd_data  <= r_mem[w_rd_addr];
            r_rd_ok    <= r_valid[w_rd_addr];
            r_rsp_idx  <= i_rd_req.addr;
            r_rsp_last <= i_rd_req.last;
        end
    end

    // One valid bit per entry; an entry never written reads as black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rsp_vld <= 1'b0;
        end else begin
            r_rsp_vld <= i_rd_req.en;
            if (w_wr_ok) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_rsp.vld  = r_rsp_vld;
    assign o_rd_rsp.last = r_rsp_last;
    assign o_rd_rsp.idx  = r_rsp_idx;
    assign o_rd_rsp.rgb  = r_rd_ok ? r_rd_data : '0;

endmodule

FILE: design/pnc_scan.sv
`timescale 1ns / 1ps

module pnc_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic [pnc_pkg::RGB_W-1:0]    i_qry_rgb,
    input  pnc_pkg::t_rd_rsp             i_rd_rsp,
    output logic [pnc_pkg::IDX_W-1:0]    o_best_index,
    output logic                         o_done
);
    import pnc_pkg::*;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        abs_diff = (a > b) ? CHAN_W'(a - b) : CHAN_W'(b - a);
    endfunction

    logic [SQ_W-1:0]   r_sq_r;
    logic [SQ_W-1:0]   r_sq_g;
    logic [SQ_W-1:0]   r_sq_b;
    logic              r_s1_vld;
    logic              r_s1_last;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0]  r_best_idx;
    logic              r_done;

    logic [CHAN_W-1:0] w_dr;
    logic [CHAN_W-1:0] w_dg;
    logic [CHAN_W-1:0] w_db;
    logic [DIST_W-1:0] w_dist;

    assign w_dr = abs_diff(i_qry_rgb[3*CHAN_W-1:2*CHAN_W], i_rd_rsp.rgb[3*CHAN_W-1:2*CHAN_W]);
    assign w_dg = abs_diff(i_qry_rgb[2*CHAN_W-1:CHAN_W], i_rd_rsp.rgb[2*CHAN_W-1:CHAN_W]);
    assign w_db = abs_diff(i_qry_rgb[CHAN_W-1:0], i_rd_rsp.rgb[CHAN_W-1:0]);

    assign w_dist = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    // Stage one squares the channel differences of the entry just read.
    always_ff @(posedge i_clk) begin
        r_sq_r    <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g    <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b    <= SQ_W'(w_db) * SQ_W'(w_db);
        r_s1_idx  <= i_rd_rsp.idx;
        r_s1_last <= i_rd_rsp.last;
    end

    // Stage two sums and keeps the running minimum. A strict compare keeps
    // the lowest index on a tie, and the all-ones start lets entry 0 win.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_done      <= 1'b0;
            r_best_dist <= '1;
            r_best_idx  <= '0;
        end else begin
            r_s1_vld <= i_rd_rsp.vld;
            r_done   <= r_s1_vld && r_s1_last;
            if (i_clear) begin
                r_best_dist <= '1;
                r_best_idx  <= '0;
            end else if (r_s1_vld && (w_dist < r_best_dist)) begin
                r_best_dist <= w_dist;
                r_best_idx  <= r_s1_idx;
            end
        end
    end

    assign o_best_index = r_best_idx;
    assign o_done       = r_done;

endmodule

FILE: design/palette_nearest_color_match_core.sv
`timescale 1ns / 1ps

// Nearest palette color match. The block keeps a palette of RGB entries, eight
// bits per channel, cleared to black at reset. A write beat (tuser low) stores
// its color at entry_index after gamma level 0, which raises each channel by
// one and saturates at 255; a write beyond the palette is dropped. A write
// produces no result beat. A query beat (tuser high) returns the index of
// the entry with the smallest squared RGB distance to its color, the lowest
// index on a tie. The palette lives in one synchronous memory with a single
// read port, and the query walks it one entry a cycle, so a query keeps the
// input closed until its result moves into the output register. The walk
// covers SPAN entries, the lesser of PALETTE_ENTRIES and 256, as only 256 can
// be addressed. Writes are taken only between queries, so a scan never reads
// an entry that is being written. A finished result waits in an output
// register, and write beats are accepted while it waits. If the result of the
// previous query still waits there when a scan ends, the input stays closed
// for every further cycle until the receiver takes that beat.
module palette_nearest_color_match_core #(
    parameter int PALETTE_ENTRIES = pnc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: entry_index[7:0], red[15:8], green[23:16], blue[31:24].
    input  logic [31:0] s_axis_tdata,
    // Field: action[0] (0 = write palette entry, 1 = query nearest color).
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Field: best_index[7:0].
    output logic [7:0]  m_axis_tdata
);
    import pnc_pkg::*;

    localparam int SPAN = (PALETTE_ENTRIES < ADDR_SPAN) ? PALETTE_ENTRIES : ADDR_SPAN;
    localparam int AW = $clog2(SPAN);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SPAN - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [AW-1:0]     r_cnt;
    logic [AW-1:0]     n_cnt;
    logic [RGB_W-1:0]  r_qry_rgb;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;

    logic              w_accept;
    logic              w_query;
    logic              w_write;
    logic              w_last;
    logic              w_load;
    logic [IDX_W-1:0]  w_index;
    logic [CHAN_W-1:0] w_red;
    logic [CHAN_W-1:0] w_green;
    logic [CHAN_W-1:0] w_blue;
    logic [RGB_W-1:0]  w_wr_rgb;
    t_rd_req           w_rd_req;
    t_rd_rsp           w_rd_rsp;
    logic [IDX_W-1:0]  w_best_index;
    logic              w_done;

    assign w_index = s_axis_tdata[7:0];
    assign w_red   = s_axis_tdata[15:8];
    assign w_green = s_axis_tdata[23:16];
    assign w_blue  = s_axis_tdata[31:24];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_query       = w_accept && (s_axis_tuser == ACT_QUERY);
    assign w_write       = w_accept && (s_axis_tuser == ACT_WRITE);

    assign w_wr_rgb = {gamma0(w_red), gamma0(w_green), gamma0(w_blue)};

    // The scan issues one read a cycle; the last address is tagged so the
    // compare stage can flag the end without its own counter.
    assign w_last        = (r_cnt == LAST_ADDR);
    assign w_rd_req.en   = (r_state == S_SCAN);
    assign w_rd_req.last = w_last;
    assign w_rd_req.addr = IDX_W'(r_cnt);

    pnc_palette_mem #(
        .DEPTH (SPAN)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_write),
        .i_wr_index (w_index),
        .i_wr_rgb   (w_wr_rgb),
        .i_rd_req   (w_rd_req),
        .o_rd_rsp   (w_rd_rsp)
    );

    pnc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_query),
        .i_qry_rgb    (r_qry_rgb),
        .i_rd_rsp     (w_rd_rsp),
        .o_best_index (w_best_index),
        .o_done       (w_done)
    );

    // The result moves into the output register once that register is free.
    assign w_load = (r_state == S_HOLD) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (w_last) begin
                    n_state = S_WAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = AW'(r_cnt + 1'b1);
                end
            end
            S_WAIT: begin
                if (w_done) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_qry_rgb <= {w_red, w_green, w_blue};
        end
        if (w_load) begin
            r_out_index <= w_best_index;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_index;

endmodule

FILE: design/pnc_checker.sv
`timescale 1ns / 1ps

module pnc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    import pnc_pkg::*;

    // A stalled result beat keeps its index.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

    // A query occupies the block, so the input closes right after it.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_QUERY)) |=> !s_axis_tready)
        else $error("input still open after a query beat");

    // A write finishes in its own cycle and leaves the input open.
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_WRITE)) |=> s_axis_tready)
        else $error("input closed after a write beat");

    // A new result appears only at the end of a scan, when the input was busy.
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result beat without a scan");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

endmodule

bind palette_nearest_color_match_core pnc_checker u_pnc_checker (.*);
